/* hw/rtl/mcv_pkg.sv */
// Shared types and constants for the MIDI-to-CV voice allocator.
`default_nettype none

package mcv_pkg;

    // Voice bank geometry
    localparam int SLOTS = 16;

    // Reset values of a voice slot
    localparam logic [6:0]  NOTE_RESET  = 7'd60;
    localparam logic [13:0] BEND_CENTRE = 14'd8192;

    // Controller numbers and the pedal threshold
    localparam logic [6:0] CC_MOD       = 7'h01;
    localparam logic [6:0] CC_SUSTAIN   = 7'h40;
    localparam logic [6:0] CC_ALL_OFF   = 7'h7b;
    localparam logic [6:0] PEDAL_THRESH = 7'd64;

    // Channel message kinds (high nibble of the status byte)
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_POLY_AT  = 4'ha;
    localparam logic [3:0] KIND_CC       = 4'hb;
    localparam logic [3:0] KIND_CHAN_AT  = 4'hd;
    localparam logic [3:0] KIND_BEND     = 4'he;

    // Status bytes from here up carry no channel
    localparam logic [7:0] STATUS_SYSTEM = 8'hf0;

    // Allocation modes
    localparam logic [1:0] MODE_ROTATE = 2'd0;
    localparam logic [1:0] MODE_REUSE  = 2'd1;
    localparam logic [1:0] MODE_RESET  = 2'd2;
    localparam logic [1:0] MODE_MPE    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FILTER = 2'd0;
    localparam logic [1:0] REG_VOICES = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
    } msg_t;

    typedef struct packed {
        logic [3:0]  voice_index;
        logic [6:0]  note_number;
        logic        gate_on;
        logic [6:0]  velocity;
        logic [6:0]  aftertouch;
        logic [13:0] pitch_bend;
        logic [6:0]  mod_wheel;
        logic        last_voice;
    } result_t;

    // One word of the voice memory (gates live in flops)
    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [6:0]  press;
        logic [13:0] bend;
        logic [6:0]  modw;
    } voice_t;

    localparam voice_t VOICE_RESET = '{
        note:  NOTE_RESET,
        vel:   7'd0,
        press: 7'd0,
        bend:  BEND_CENTRE,
        modw:  7'd0
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_HRD,
        ST_HCHK,
        ST_HEND,
        ST_PUSH,
        ST_PICK,
        ST_ROT,
        ST_SRD,
        ST_SWR,
        ST_SEND,
        ST_TRD,
        ST_TUSE,
        ST_OUT
    } state_t;

    // Per-slot operation applied during a voice memory scan
    typedef enum logic [3:0] {
        OP_POLY_AT,
        OP_MOD,
        OP_BEND,
        OP_PRESS,
        OP_PEDAL,
        OP_REUSE,
        OP_UP,
        OP_NOTE,
        OP_TOP
    } op_t;

endpackage

`default_nettype wire

/* hw/rtl/midi_to_cv_voice_allocator.sv */
// Top level of the MIDI-to-CV voice allocator: sequencer, voice memory and held-note stack.
//
// Usage: raise start with a message on msg; it is transferred when start is high and busy
// is low. A panic item (func set) clears every voice. The block then emits 16 results,
// one per voice slot, each on result for exactly one cycle with result_valid high;
// last_voice marks slot 15. The receiver cannot hold results off.
// Configuration goes over cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// high only while idle. A change of voice count or mode clears the voice state.
// Work per item: the held-stack search walks the stack memory one entry at a time, the rotate
// search checks one slot per cycle, and the voice memory scan reads then writes back each slot.
// With a shallow stack that is full, a second stack walk drops the oldest note. Results follow
// as a burst on consecutive cycles, each slot passing the registered memory read, then the
// output register.
// Reset: asynchronous, active low; voices read back as their reset values through
// per-slot valid bits, so no clearing pass is needed. The held stack needs no clearing.
`default_nettype none

module midi_to_cv_voice_allocator #(
    parameter int MAX_VOICES = 16,
    parameter int HELD_DEPTH = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mcv_pkg::msg_t     msg,
    output logic                   result_valid,
    output mcv_pkg::result_t       result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [4:0]        cfg_data
);

    import mcv_pkg::*;

    localparam int IW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int CW = $clog2(HELD_DEPTH + 1);

    // Memories
    voice_t     vmem [SLOTS];
    logic [6:0] hmem [HELD_DEPTH];

    // Control state
    state_t      state_reg, state_next;
    logic [4:0]  filter_reg, filter_next;
    logic [4:0]  vc_reg, vc_next;
    logic [1:0]  mode_reg, mode_next;
    logic        sustain_reg, sustain_next;
    logic [4:0]  ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [127:0] held_map_reg, held_map_next;
    logic [15:0] valid_reg, valid_next;
    logic [15:0] gate_reg, gate_next;
    logic        res_valid_reg, res_valid_next;
    logic [3:0]  out_k_reg, out_k_next;
    logic        v_rout_reg, v_rout_next;

    // Working registers
    msg_t        msg_reg, msg_next;
    logic [CW-1:0] h_idx_reg, h_idx_next;
    logic        found_reg, found_next;
    logic        drop_reg, drop_next;
    logic        down_reg, down_next;
    op_t         op_reg, op_next;
    logic [3:0]  scan_k_reg, scan_k_next;
    logic [3:0]  scan_end_reg, scan_end_next;
    logic [3:0]  v_reg, v_next;
    logic [4:0]  rot_i_reg, rot_i_next;
    logic [6:0]  note0_reg, note0_next;
    logic [6:0]  top_reg, top_next;
    logic        top_gate_reg, top_gate_next;
    result_t     res_reg, res_next;
    voice_t      v_rdata_reg;
    logic [3:0]  v_ridx_reg;
    logic [6:0]  h_rdata_reg;

    // Memory port controls
    logic        v_re, v_we;
    logic [3:0]  v_raddr, v_waddr;
    voice_t      v_wdata;
    logic        h_re, h_we;
    logic [IW-1:0] h_raddr, h_waddr;
    logic [6:0]  h_wdata;

    // Helpers
    logic        do_clear;
    voice_t      ve, vw;
    logic [3:0]  kind, chan;
    logic [6:0]  d1, d2;
    logic        pass;
    logic [4:0]  vc_sat;
    logic [3:0]  last_slot;
    logic [4:0]  ptr_inc, ptr_step;
    logic [3:0]  free_idx;
    logic        free_found;
    logic [CW-1:0] h_idx_m1, count_m1;
    logic        h_match;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign kind      = msg_reg.status_byte[7:4];
    assign chan      = msg_reg.status_byte[3:0];
    assign d1        = msg_reg.data_one;
    assign d2        = msg_reg.data_two;
    assign last_slot = 4'(vc_reg - 5'd1);
    assign h_idx_m1  = h_idx_reg - CW'(1);
    assign count_m1  = count_reg - CW'(1);

    // Entry read back from the voice memory, reset value if never written
    assign ve = valid_reg[v_ridx_reg] ? v_rdata_reg : VOICE_RESET;

    // Channel filter
    always_comb
    begin
        pass = 1'b1;
        if (filter_reg != 5'd0 && msg_reg.status_byte < STATUS_SYSTEM)
        begin
            pass = ({1'b0, chan} == 5'(filter_reg - 5'd1));
        end
    end

    // Voice count saturation
    always_comb
    begin
        vc_sat = cfg_data;
        if (cfg_data == 5'd0)
        begin
            vc_sat = 5'd1;
        end
        else if (cfg_data > 5'(MAX_VOICES))
        begin
            vc_sat = 5'(MAX_VOICES);
        end
    end

    // Rotate pointer step, wrapping at the voice count
    always_comb
    begin
        ptr_inc  = ptr_reg + 5'd1;
        ptr_step = (ptr_inc >= vc_reg) ? 5'd0 : ptr_inc;
    end

    // First free voice for reset mode, else the last voice in use
    always_comb
    begin
        free_idx   = last_slot;
        free_found = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (!free_found && (5'(k) < vc_reg) && !gate_reg[k])
            begin
                free_idx   = 4'(k);
                free_found = 1'b1;
            end
        end
    end

    // Stack entry match: by note, or the oldest entry when dropping
    assign h_match = drop_reg ? (h_idx_reg == CW'(0)) : (h_rdata_reg == d1);

    // Sequencer: next state, memory controls and working registers
    always_comb
    begin
        state_next     = state_reg;
        filter_next    = filter_reg;
        vc_next        = vc_reg;
        mode_next      = mode_reg;
        sustain_next   = sustain_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        held_map_next  = held_map_reg;
        valid_next     = valid_reg;
        gate_next      = gate_reg;
        msg_next       = msg_reg;
        h_idx_next     = h_idx_reg;
        found_next     = found_reg;
        drop_next      = drop_reg;
        down_next      = down_reg;
        op_next        = op_reg;
        scan_k_next    = scan_k_reg;
        scan_end_next  = scan_end_reg;
        v_next         = v_reg;
        rot_i_next     = rot_i_reg;
        note0_next     = note0_reg;
        top_next       = top_reg;
        top_gate_next  = top_gate_reg;
        out_k_next     = (state_reg == ST_OUT) ? 4'(out_k_reg + 4'd1) : 4'd0;
        v_rout_next    = 1'b0;
        do_clear       = 1'b0;

        v_re    = 1'b0;
        v_raddr = scan_k_reg;
        v_we    = 1'b0;
        v_waddr = scan_k_reg;
        vw      = ve;
        h_re    = 1'b0;
        h_raddr = h_idx_reg[IW-1:0];
        h_we    = 1'b0;
        h_waddr = count_reg[IW-1:0];
        h_wdata = d1;

        // Output register takes the voice memory read data in the cycle after it arrives
        res_valid_next = v_rout_reg;
        res_next       = res_reg;
        if (v_rout_reg)
        begin
            res_next.voice_index = v_ridx_reg;
            res_next.note_number = ve.note;
            res_next.gate_on     = gate_reg[v_ridx_reg];
            res_next.velocity    = ve.vel;
            res_next.aftertouch  = ve.press;
            res_next.pitch_bend  = ve.bend;
            res_next.mod_wheel   = ve.modw;
            res_next.last_voice  = (v_ridx_reg == 4'(SLOTS - 1));
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        REG_FILTER: filter_next = cfg_data;
                        REG_VOICES:
                        begin
                            if (vc_sat != vc_reg)
                            begin
                                vc_next  = vc_sat;
                                do_clear = 1'b1;
                            end
                        end
                        REG_MODE:
                        begin
                            if (cfg_data[1:0] != mode_reg)
                            begin
                                mode_next = cfg_data[1:0];
                                do_clear  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                if (start)
                begin
                    msg_next   = msg;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                h_idx_next = '0;
                found_next = 1'b0;
                drop_next  = 1'b0;
                state_next = ST_OUT;
                if (msg_reg.func)
                begin
                    do_clear = 1'b1;
                end
                else if (pass)
                begin
                    case (kind)
                        KIND_NOTE_OFF, KIND_NOTE_ON:
                        begin
                            down_next  = (kind == KIND_NOTE_ON) && (d2 != 7'd0);
                            state_next = held_map_reg[d1] ? ST_HRD : ST_HEND;
                        end
                        KIND_POLY_AT:
                        begin
                            op_next       = OP_POLY_AT;
                            scan_k_next   = 4'd0;
                            scan_end_next = 4'(SLOTS - 1);
                            state_next    = ST_SRD;
                        end
                        KIND_CC:
                        begin
                            if (d1 == CC_MOD)
                            begin
                                op_next       = OP_MOD;
                                scan_k_next   = (mode_reg == MODE_MPE) ? chan : 4'd0;
                                scan_end_next = (mode_reg == MODE_MPE) ? chan : 4'd0;
                                state_next    = ST_SRD;
                            end
                            else if (d1 == CC_SUSTAIN)
                            begin
                                if (d2 >= PEDAL_THRESH)
                                begin
                                    sustain_next = 1'b1;
                                end
                                else if (sustain_reg)
                                begin
                                    // Pedal released
                                    sustain_next = 1'b0;
                                    if (vc_reg == 5'd1)
                                    begin
                                        if (count_reg != CW'(0))
                                        begin
                                            top_gate_next = 1'b0;
                                            state_next    = ST_TRD;
                                        end
                                    end
                                    else
                                    begin
                                        op_next       = OP_PEDAL;
                                        scan_k_next   = 4'd0;
                                        scan_end_next = last_slot;
                                        state_next    = ST_SRD;
                                    end
                                end
                            end
                            else if (d1 == CC_ALL_OFF && d2 == 7'd0)
                            begin
                                do_clear = 1'b1;
                            end
                        end
                        KIND_CHAN_AT:
                        begin
                            op_next       = OP_PRESS;
                            scan_k_next   = (mode_reg == MODE_MPE) ? chan : 4'd0;
                            scan_end_next = (mode_reg == MODE_MPE) ? chan : 4'(SLOTS - 1);
                            state_next    = ST_SRD;
                        end
                        KIND_BEND:
                        begin
                            op_next       = OP_BEND;
                            scan_k_next   = (mode_reg == MODE_MPE) ? chan : 4'd0;
                            scan_end_next = (mode_reg == MODE_MPE) ? chan : 4'd0;
                            state_next    = ST_SRD;
                        end
                        default: ;
                    endcase
                end
            end

            // Held stack walk: find the entry, then close the gap behind it
            ST_HRD:
            begin
                if (h_idx_reg >= count_reg)
                begin
                    state_next = ST_HEND;
                end
                else
                begin
                    h_re       = 1'b1;
                    state_next = ST_HCHK;
                end
            end

            ST_HCHK:
            begin
                if (found_reg)
                begin
                    h_we    = 1'b1;
                    h_waddr = h_idx_m1[IW-1:0];
                    h_wdata = h_rdata_reg;
                end
                if (h_match && !found_reg)
                begin
                    found_next = 1'b1;
                    if (drop_reg)
                    begin
                        held_map_next[h_rdata_reg] = 1'b0;
                    end
                end
                h_idx_next = h_idx_reg + CW'(1);
                state_next = ST_HRD;
            end

            ST_HEND:
            begin
                if (found_reg)
                begin
                    count_next = count_m1;
                    if (!drop_reg)
                    begin
                        held_map_next[d1] = 1'b0;
                    end
                end
                if (drop_reg || down_reg)
                begin
                    state_next = ST_PUSH;
                end
                else if (sustain_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    op_next       = OP_UP;
                    scan_k_next   = 4'd0;
                    scan_end_next = last_slot;
                    state_next    = ST_SRD;
                end
            end

            ST_PUSH:
            begin
                if (count_reg >= CW'(HELD_DEPTH) && !drop_reg)
                begin
                    // Full stack: drop the oldest note first
                    drop_next  = 1'b1;
                    h_idx_next = '0;
                    found_next = 1'b0;
                    state_next = ST_HRD;
                end
                else
                begin
                    h_we              = 1'b1;
                    count_next        = count_reg + CW'(1);
                    held_map_next[d1] = 1'b1;
                    drop_next         = 1'b0;
                    state_next        = ST_PICK;
                end
            end

            // Voice choice
            ST_PICK:
            begin
                found_next = 1'b0;
                rot_i_next = 5'd0;
                op_next    = OP_NOTE;
                state_next = ST_SRD;
                if (mode_reg == MODE_MPE)
                begin
                    v_next        = chan;
                    scan_k_next   = chan;
                    scan_end_next = chan;
                end
                else if (vc_reg == 5'd1)
                begin
                    v_next        = 4'd0;
                    scan_k_next   = 4'd0;
                    scan_end_next = 4'd0;
                end
                else if (mode_reg == MODE_REUSE)
                begin
                    op_next       = OP_REUSE;
                    scan_k_next   = 4'd0;
                    scan_end_next = last_slot;
                end
                else if (mode_reg == MODE_ROTATE)
                begin
                    state_next = ST_ROT;
                end
                else
                begin
                    v_next        = free_idx;
                    scan_k_next   = free_idx;
                    scan_end_next = free_idx;
                end
            end

            // Rotate search, one slot a cycle; the step after a full lap is taken as is
            ST_ROT:
            begin
                ptr_next   = ptr_step;
                rot_i_next = rot_i_reg + 5'd1;
                if (rot_i_reg == vc_reg || !gate_reg[ptr_step[3:0]])
                begin
                    op_next       = OP_NOTE;
                    v_next        = ptr_step[3:0];
                    scan_k_next   = ptr_step[3:0];
                    scan_end_next = ptr_step[3:0];
                    state_next    = ST_SRD;
                end
            end

            // Voice memory scan: read, then modify and write back
            ST_SRD:
            begin
                v_re       = 1'b1;
                state_next = ST_SWR;
            end

            ST_SWR:
            begin
                case (op_reg)
                    OP_POLY_AT:
                    begin
                        if (ve.note == d1)
                        begin
                            vw.press = d2;
                        end
                        v_we = 1'b1;
                    end
                    OP_MOD:
                    begin
                        vw.modw = d2;
                        v_we    = 1'b1;
                    end
                    OP_BEND:
                    begin
                        vw.bend = {d2, d1};
                        v_we    = 1'b1;
                    end
                    OP_PRESS:
                    begin
                        vw.press = d1;
                        v_we     = 1'b1;
                    end
                    OP_PEDAL:
                    begin
                        if (gate_reg[scan_k_reg])
                        begin
                            gate_next[scan_k_reg] = held_map_reg[ve.note];
                        end
                    end
                    OP_REUSE:
                    begin
                        if (ve.note == d1 && !found_reg)
                        begin
                            found_next = 1'b1;
                            v_next     = scan_k_reg;
                        end
                    end
                    OP_UP:
                    begin
                        if (ve.note == d1)
                        begin
                            gate_next[scan_k_reg] = 1'b0;
                        end
                        if (scan_k_reg == 4'd0)
                        begin
                            note0_next = ve.note;
                        end
                    end
                    OP_NOTE:
                    begin
                        vw.note               = d1;
                        vw.vel                = d2;
                        gate_next[scan_k_reg] = 1'b1;
                        v_we                  = 1'b1;
                    end
                    OP_TOP:
                    begin
                        vw.note = top_reg;
                        if (top_gate_reg)
                        begin
                            gate_next[scan_k_reg] = 1'b1;
                        end
                        v_we = 1'b1;
                    end
                    default: ;
                endcase
                if (v_we)
                begin
                    valid_next[scan_k_reg] = 1'b1;
                end
                if (scan_k_reg == scan_end_reg)
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    scan_k_next = scan_k_reg + 4'd1;
                    state_next  = ST_SRD;
                end
            end

            ST_SEND:
            begin
                state_next = ST_OUT;
                case (op_reg)
                    OP_REUSE:
                    begin
                        if (found_reg)
                        begin
                            op_next       = OP_NOTE;
                            scan_k_next   = v_reg;
                            scan_end_next = v_reg;
                            state_next    = ST_SRD;
                        end
                        else
                        begin
                            rot_i_next = 5'd0;
                            state_next = ST_ROT;
                        end
                    end
                    OP_UP:
                    begin
                        // Mono: fall back to the most recent held note
                        if (vc_reg == 5'd1 && d1 == note0_reg && count_reg != CW'(0))
                        begin
                            top_gate_next = 1'b1;
                            state_next    = ST_TRD;
                        end
                    end
                    default: ;
                endcase
            end

            // Read the top of the held stack
            ST_TRD:
            begin
                h_re       = 1'b1;
                h_raddr    = count_m1[IW-1:0];
                state_next = ST_TUSE;
            end

            ST_TUSE:
            begin
                top_next      = h_rdata_reg;
                op_next       = OP_TOP;
                scan_k_next   = 4'd0;
                scan_end_next = 4'd0;
                state_next    = ST_SRD;
            end

            // Read out all slots, one a cycle
            ST_OUT:
            begin
                v_re        = 1'b1;
                v_raddr     = out_k_reg;
                v_rout_next = 1'b1;
                if (out_k_reg == 4'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        v_wdata = vw;

        // Panic, all notes off or voice reconfiguration
        if (do_clear)
        begin
            valid_next    = '0;
            gate_next     = '0;
            sustain_next  = 1'b0;
            ptr_next      = 5'h1f;
            count_next    = '0;
            held_map_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filter_reg    <= 5'd0;
            vc_reg        <= 5'd1;
            mode_reg      <= MODE_ROTATE;
            sustain_reg   <= 1'b0;
            ptr_reg       <= 5'h1f;
            count_reg     <= '0;
            held_map_reg  <= '0;
            valid_reg     <= '0;
            gate_reg      <= '0;
            res_valid_reg <= 1'b0;
            out_k_reg     <= 4'd0;
            v_rout_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filter_reg    <= filter_next;
            vc_reg        <= vc_next;
            mode_reg      <= mode_next;
            sustain_reg   <= sustain_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            held_map_reg  <= held_map_next;
            valid_reg     <= valid_next;
            gate_reg      <= gate_next;
            res_valid_reg <= res_valid_next;
            out_k_reg     <= out_k_next;
            v_rout_reg    <= v_rout_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        msg_reg      <= msg_next;
        h_idx_reg    <= h_idx_next;
        found_reg    <= found_next;
        drop_reg     <= drop_next;
        down_reg     <= down_next;
        op_reg       <= op_next;
        scan_k_reg   <= scan_k_next;
        scan_end_reg <= scan_end_next;
        v_reg        <= v_next;
        rot_i_reg    <= rot_i_next;
        note0_reg    <= note0_next;
        top_reg      <= top_next;
        top_gate_reg <= top_gate_next;
        res_reg      <= res_next;
    end

    // Voice memory, registered read
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            v_rdata_reg <= vmem[v_raddr];
            v_ridx_reg  <= v_raddr;
        end
    end

    // Held-note stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            hmem[h_waddr] <= h_wdata;
        end
        if (h_re)
        begin
            h_rdata_reg <= hmem[h_raddr];
        end
    end

endmodule

`default_nettype wire

/* tb/sv/mcv_checker.sv */
// Checker for the MIDI-to-CV voice allocator: watches transfers, predicts voice slots, compares.
`default_nettype none

module mcv_checker
    import mcv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire msg_t    msg,
    input  wire logic    result_valid,
    input  wire result_t result,
    input  wire logic    cfg_valid,
    input  wire logic    cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data,
    output int           fail_count,
    output int           pending
);

    // Predicted register and voice state
    logic [4:0]  flt;
    logic [4:0]  nvoices;
    logic [1:0]  mode;
    logic [6:0]  v_note [SLOTS];
    logic        v_gate [SLOTS];
    logic [6:0]  v_vel  [SLOTS];
    logic [6:0]  v_press[SLOTS];
    logic [13:0] v_bend [SLOTS];
    logic [6:0]  v_mod  [SLOTS];
    logic        pedal;
    int          rot_ptr;
    logic [6:0]  held [128];
    int          held_n;

    result_t slot_queue[$];

    assign pending = slot_queue.size();

    function automatic void clear_bank();
        for (int k = 0; k < SLOTS; k++)
        begin
            v_note[k] = NOTE_RESET; v_gate[k] = 0; v_vel[k] = 0;
            v_press[k] = 0; v_bend[k] = BEND_CENTRE; v_mod[k] = 0;
        end
        pedal = 0; rot_ptr = -1; held_n = 0;
    endfunction

    function automatic void held_drop(logic [6:0] n);
        for (int i = 0; i < held_n; i++)
        begin
            if (held[i] == n)
            begin
                for (int j = i; j + 1 < held_n; j++) held[j] = held[j + 1];
                held_n--;
                return;
            end
        end
    endfunction

    function automatic bit held_has(logic [6:0] n);
        for (int i = 0; i < held_n; i++) if (held[i] == n) return 1;
        return 0;
    endfunction

    function automatic int next_rotate(int n);
        for (int i = 0; i < n; i++)
        begin
            rot_ptr++;
            if (rot_ptr >= n) rot_ptr = 0;
            if (!v_gate[rot_ptr]) return rot_ptr;
        end
        rot_ptr++;
        if (rot_ptr >= n) rot_ptr = 0;
        return rot_ptr;
    endfunction

    function automatic int choose_voice(logic [6:0] n);
        int cnt;
        cnt = nvoices;
        if (cnt == 1) return 0;
        if (mode == MODE_REUSE)
        begin
            for (int k = 0; k < cnt; k++) if (v_note[k] == n) return k;
            return next_rotate(cnt);
        end
        if (mode == MODE_ROTATE) return next_rotate(cnt);
        if (mode == MODE_RESET)
        begin
            for (int k = 0; k < cnt; k++) if (!v_gate[k]) return k;
            return cnt - 1;
        end
        return 0;
    endfunction

    function automatic void release_note(logic [6:0] n);
        held_drop(n);
        if (pedal) return;
        for (int k = 0; k < nvoices; k++) if (v_note[k] == n) v_gate[k] = 0;
        if (nvoices == 1 && n == v_note[0] && held_n > 0)
        begin
            v_note[0] = held[held_n - 1];
            v_gate[0] = 1;
        end
    endfunction

    function automatic void press_note(logic [6:0] n, logic [6:0] vel, int ch);
        int v;
        held_drop(n);
        held[held_n] = n;
        held_n++;
        v = (mode == MODE_MPE) ? ch : choose_voice(n);
        v = v & 15;
        v_note[v] = n; v_gate[v] = 1; v_vel[v] = vel;
    endfunction

    function automatic void lift_pedal();
        if (!pedal) return;
        pedal = 0;
        if (nvoices == 1)
        begin
            if (held_n > 0) v_note[0] = held[held_n - 1];
            return;
        end
        for (int k = 0; k < nvoices; k++)
            if (v_gate[k]) v_gate[k] = held_has(v_note[k]);
    endfunction

    function automatic void apply_message(msg_t m);
        int ch;
        logic [6:0] d1, d2;
        ch = m.status_byte[3:0];
        d1 = m.data_one;
        d2 = m.data_two;
        case (m.status_byte[7:4])
            KIND_NOTE_OFF: release_note(d1);
            KIND_NOTE_ON:
                if (d2 > 0) press_note(d1, d2, ch);
                else release_note(d1);
            KIND_POLY_AT:
                for (int k = 0; k < SLOTS; k++) if (v_note[k] == d1) v_press[k] = d2;
            KIND_CC:
                if (d1 == CC_MOD) v_mod[(mode == MODE_MPE) ? ch : 0] = d2;
                else if (d1 == CC_SUSTAIN)
                begin
                    if (d2 >= PEDAL_THRESH) pedal = 1;
                    else lift_pedal();
                end
                else if (d1 == CC_ALL_OFF && d2 == 0) clear_bank();
            KIND_CHAN_AT:
                if (mode == MODE_MPE) v_press[ch] = d1;
                else for (int k = 0; k < SLOTS; k++) v_press[k] = d1;
            KIND_BEND:
                v_bend[(mode == MODE_MPE) ? ch : 0] = {d2, d1};
            default: ;
        endcase
    endfunction

    // Work out the 16 slot results of one accepted item
    function automatic void predict_item(msg_t m);
        result_t r;
        if (m.func) clear_bank();
        else if (flt == 0 || m.status_byte >= STATUS_SYSTEM
                 || m.status_byte[3:0] == flt - 5'd1)
            apply_message(m);
        for (int k = 0; k < SLOTS; k++)
        begin
            r.voice_index = k[3:0];
            r.note_number = v_note[k];
            r.gate_on     = v_gate[k];
            r.velocity    = v_vel[k];
            r.aftertouch  = v_press[k];
            r.pitch_bend  = v_bend[k];
            r.mod_wheel   = v_mod[k];
            r.last_voice  = (k == SLOTS - 1);
            slot_queue.push_back(r);
        end
    endfunction

    function automatic void write_register(logic [1:0] idx, logic [4:0] val);
        logic [4:0] v;
        if (idx == REG_FILTER) flt = val;
        else if (idx == REG_VOICES)
        begin
            v = (val < 1) ? 5'd1 : (val > 16) ? 5'd16 : val;
            if (v != nvoices)
            begin
                nvoices = v;
                clear_bank();
            end
        end
        else if (idx == REG_MODE)
        begin
            if (val[1:0] != mode)
            begin
                mode = val[1:0];
                clear_bank();
            end
        end
    endfunction

    // Field comparison of one result transfer
    function automatic void compare_slot(result_t a);
        result_t e;
        if (slot_queue.size() == 0)
        begin
            $error("unexpected result for voice %0d", a.voice_index);
            fail_count++;
            return;
        end
        e = slot_queue.pop_front();
        if (a.voice_index !== e.voice_index)
        begin
            $error("voice_index: expected %0d got %0d", e.voice_index, a.voice_index);
            fail_count++;
        end
        if (a.note_number !== e.note_number)
        begin
            $error("note_number: expected %0d got %0d", e.note_number, a.note_number);
            fail_count++;
        end
        if (a.gate_on !== e.gate_on)
        begin
            $error("gate_on: expected %0d got %0d", e.gate_on, a.gate_on);
            fail_count++;
        end
        if (a.velocity !== e.velocity)
        begin
            $error("velocity: expected %0d got %0d", e.velocity, a.velocity);
            fail_count++;
        end
        if (a.aftertouch !== e.aftertouch)
        begin
            $error("aftertouch: expected %0d got %0d", e.aftertouch, a.aftertouch);
            fail_count++;
        end
        if (a.pitch_bend !== e.pitch_bend)
        begin
            $error("pitch_bend: expected %0d got %0d", e.pitch_bend, a.pitch_bend);
            fail_count++;
        end
        if (a.mod_wheel !== e.mod_wheel)
        begin
            $error("mod_wheel: expected %0d got %0d", e.mod_wheel, a.mod_wheel);
            fail_count++;
        end
        if (a.last_voice !== e.last_voice)
        begin
            $error("last_voice: expected %0d got %0d", e.last_voice, a.last_voice);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        flt = 0; nvoices = 1; mode = MODE_ROTATE;
        clear_bank();
    end

    // Sample every transfer at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid) compare_slot(result);
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (start && !busy) predict_item(msg);
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench top for the MIDI-to-CV voice allocator: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
    import mcv_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    msg_t       msg;
    logic       result_valid;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    int         fail_count;
    int         pending;
    bit         quiet;

    midi_to_cv_voice_allocator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .msg(msg),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mcv_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .msg(msg),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // Send one item; start holds high across back-to-back items, save for random gaps when not quiet
    task automatic send_item(bit fn, logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start <= 1'b1;
        msg   <= '{func: fn, status_byte: st, data_one: d1, data_two: d2};
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        send_item(1'b0, st, d1, d2);
    endtask

    // Drain results, then write a register while idle
    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(logic [4:0] f, logic [4:0] n, logic [1:0] m);
        write_reg(REG_FILTER, f);
        write_reg(REG_VOICES, n);
        write_reg(REG_MODE, m);
    endtask

    // Musical traffic with random content, biased towards notes
    task automatic random_item(logic [3:0] ch);
        int     pick;
        logic [3:0] c;
        logic [6:0] nt;
        pick = $urandom_range(0, 99);
        c  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : ch;
        nt = 7'($urandom_range(55, 66));
        if (pick < 35)      send_msg({KIND_NOTE_ON, c}, nt, 7'($urandom_range(1, 127)));
        else if (pick < 55) send_msg({KIND_NOTE_OFF, c}, nt, 7'($urandom));
        else if (pick < 60) send_msg({KIND_NOTE_ON, c}, nt, 7'd0);
        else if (pick < 66) send_msg({KIND_CC, c}, CC_SUSTAIN, 7'($urandom));
        else if (pick < 70) send_msg({KIND_CC, c}, CC_MOD, 7'($urandom));
        else if (pick < 74) send_msg({KIND_BEND, c}, 7'($urandom), 7'($urandom));
        else if (pick < 78) send_msg({KIND_POLY_AT, c}, nt, 7'($urandom));
        else if (pick < 82) send_msg({KIND_CHAN_AT, c}, 7'($urandom), 7'($urandom));
        else if (pick < 84) send_msg({KIND_CC, c}, CC_ALL_OFF, 7'($urandom_range(0, 1)));
        else if (pick < 85) send_item(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
        else send_msg(8'($urandom), 7'($urandom), 7'($urandom));
    endtask

    initial
    begin
        #2000000;
        $display("midi_to_cv_voice_allocator: mismatch");
        $finish;
    end

    initial
    begin
        start = 0; msg = '0; cfg_valid = 0; cfg_index = REG_FILTER; cfg_data = 0;
        quiet = 0;
        rst_n = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: mono last-note priority, pedal, extremes
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127);
        send_msg({KIND_NOTE_ON, 4'hf}, 7'd127, 7'd1);
        send_msg({KIND_NOTE_OFF, 4'h0}, 7'd127, 7'd0);
        send_msg({KIND_CC, 4'h0}, CC_SUSTAIN, 7'd127);
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd0);
        send_msg({KIND_CC, 4'h0}, CC_SUSTAIN, 7'd63);
        send_msg({KIND_BEND, 4'h3}, 7'd127, 7'd127);
        send_msg({KIND_BEND, 4'h3}, 7'd0, 7'd0);
        send_msg({KIND_CC, 4'h0}, CC_MOD, 7'd127);
        send_msg({KIND_CC, 4'h0}, 7'd7, 7'd99);
        send_msg({KIND_POLY_AT, 4'h0}, 7'd60, 7'd127);
        send_msg({KIND_CHAN_AT, 4'h0}, 7'd127, 7'd0);
        send_msg(8'hc5, 7'd3, 7'd3);
        send_msg(8'hff, 7'd127, 7'd127);
        send_msg(8'h7f, 7'd1, 7'd1);
        send_msg({KIND_CC, 4'h0}, CC_ALL_OFF, 7'd1);
        send_msg({KIND_CC, 4'h0}, CC_ALL_OFF, 7'd0);
        send_item(1'b1, 8'hff, 7'h7f, 7'h7f);

        // Filter on channel 16, then an unmatchable filter
        setup(5'd16, 5'd0, MODE_ROTATE);
        send_msg({KIND_NOTE_ON, 4'hf}, 7'd64, 7'd90);
        send_msg({KIND_NOTE_ON, 4'h2}, 7'd65, 7'd90);
        setup(5'd31, 5'd31, MODE_MPE);
        send_msg({KIND_NOTE_ON, 4'h0}, 7'd66, 7'd90);
        send_msg(8'hf8, 7'd0, 7'd0);

        // Random phases over all modes, with one voice, sixteen voices and random voice counts
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [4:0] nv;
            logic [3:0] ch;
            nv = (ph == 0) ? 5'd1 : (ph == 1) ? 5'd16 : 5'($urandom_range(2, 16));
            ch = 4'($urandom);
            setup((ph % 3 == 2) ? 5'(ch + 1) : 5'd0, nv, 2'(ph));
            if (ph >= 6) quiet = 1;
            for (int i = 0; i < 17; i++) random_item(ch);
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("midi_to_cv_voice_allocator: match");
        else
            $display("midi_to_cv_voice_allocator: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
